// ===== hdl/grid_q_learning_step_defines.svh =====
// ----------------------------------------------------------------------------
// grid_q_learning_step_defines
// Assertion helpers shared by the grid Q-learning step RTL.
// ----------------------------------------------------------------------------
`ifndef GRID_Q_LEARNING_STEP_DEFINES_SVH
`define GRID_Q_LEARNING_STEP_DEFINES_SVH

// same-cycle implication, sampled on clk, off while rst_n is low
`define GQLS_ASSERT_SAME(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// next-cycle implication, sampled on clk, off while rst_n is low
`define GQLS_ASSERT_NEXT(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

// ===== hdl/gqls_pkg.sv =====
// ----------------------------------------------------------------------------
// gqls_pkg
// Types, constants and codes for the grid Q-learning step block.
// ----------------------------------------------------------------------------
package gqls_pkg;

    // default geometry and value format
    localparam int GRID_DIM_DEF    = 5;
    localparam int VALUE_WIDTH_DEF = 16;
    localparam int COORD_W_DEF     = 3;

    localparam int NUM_ACT  = 4;
    localparam int ACT_W    = 2;
    localparam int DRAW_W   = 16;
    localparam int RATE_W   = 16;
    localparam int EPS_W    = 17;
    localparam int LIMIT_W  = 6;
    localparam int STEPS_W  = 32;
    localparam int SCAN_W   = 3;
    localparam int MUL_SHIFT = 16;

    // step penalty is -(1.0 / 100) in the Q format, rounded to nearest (half up)
    localparam longint PENALTY_BIAS = 50;
    localparam longint PENALTY_DIV  = 100;

    // configuration port
    localparam int CFG_IDX_W  = 3;
    localparam int CFG_DATA_W = 17;

    localparam logic [RATE_W-1:0]  LEARN_RATE_RST = 16'd6554;
    localparam logic [RATE_W-1:0]  DISCOUNT_RST   = 16'd58982;
    localparam logic [EPS_W-1:0]   START_EPS_RST  = 17'd65536;
    localparam logic [RATE_W-1:0]  DECAY_RST      = 16'd64881;
    localparam logic [EPS_W-1:0]   FLOOR_EPS_RST  = 17'd6554;
    localparam logic [LIMIT_W-1:0] EP_LIMIT_RST   = 6'd50;

    localparam logic OP_TRAIN = 1'b0;
    localparam logic OP_READ  = 1'b1;

    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_LEARN_RATE    = 3'd0,
        CFG_DISCOUNT      = 3'd1,
        CFG_START_EPSILON = 3'd2,
        CFG_DECAY_FACTOR  = 3'd3,
        CFG_FLOOR_EPSILON = 3'd4,
        CFG_EPISODE_LIMIT = 3'd5
    } cfg_index_t;

    typedef enum logic [ACT_W-1:0] {
        ACT_X_DOWN = 2'd0,
        ACT_X_UP   = 2'd1,
        ACT_Y_DOWN = 2'd2,
        ACT_Y_UP   = 2'd3
    } action_t;

    typedef enum logic [3:0] {
        ST_CLEAR,
        ST_IDLE,
        ST_READ,
        ST_SCAN_CUR,
        ST_MOVE,
        ST_SCAN_NXT,
        ST_PICK_NXT,
        ST_GAMMA,
        ST_DELTA,
        ST_ALPHA,
        ST_WRITE,
        ST_DECAY,
        ST_DONE
    } state_t;

    typedef struct packed {
        logic [RATE_W-1:0]  learn_rate;
        logic [RATE_W-1:0]  discount;
        logic [EPS_W-1:0]   start_epsilon;
        logic [RATE_W-1:0]  decay_factor;
        logic [EPS_W-1:0]   floor_epsilon;
        logic [LIMIT_W-1:0] episode_limit;
    } cfg_t;

endpackage

// ===== hdl/gqls_if.sv =====
// ----------------------------------------------------------------------------
// gqls_if
// Valid/ready channels of the grid Q-learning step block: command and result.
// ----------------------------------------------------------------------------
interface gqls_cmd_if #(
    parameter int COORD_W = gqls_pkg::COORD_W_DEF
) ();
    logic                        valid;
    logic                        ready;
    logic                        operation;
    logic [gqls_pkg::DRAW_W-1:0] explore_draw;
    logic [gqls_pkg::ACT_W-1:0]  random_action;
    logic [gqls_pkg::DRAW_W-1:0] next_explore_draw;
    logic [gqls_pkg::ACT_W-1:0]  next_random_action;
    logic [COORD_W-1:0]          read_x;
    logic [COORD_W-1:0]          read_y;
    logic [gqls_pkg::ACT_W-1:0]  read_action;

    modport source (
        output valid, operation, explore_draw, random_action, next_explore_draw,
               next_random_action, read_x, read_y, read_action,
        input  ready
    );
    modport sink (
        input  valid, operation, explore_draw, random_action, next_explore_draw,
               next_random_action, read_x, read_y, read_action,
        output ready
    );
endinterface

interface gqls_res_if #(
    parameter int COORD_W     = gqls_pkg::COORD_W_DEF,
    parameter int VALUE_WIDTH = gqls_pkg::VALUE_WIDTH_DEF
) ();
    logic                         valid;
    logic                         ready;
    logic [gqls_pkg::ACT_W-1:0]   chosen_action;
    logic [COORD_W-1:0]           new_x;
    logic [COORD_W-1:0]           new_y;
    logic                         goal_reached;
    logic                         episode_over;
    logic [gqls_pkg::STEPS_W-1:0] steps_total;
    logic signed [VALUE_WIDTH-1:0] q_value;

    modport source (
        output valid, chosen_action, new_x, new_y, goal_reached, episode_over,
               steps_total, q_value,
        input  ready
    );
    modport sink (
        input  valid, chosen_action, new_x, new_y, goal_reached, episode_over,
               steps_total, q_value,
        output ready
    );
endinterface

// ===== hdl/gqls_ram.sv =====
// ----------------------------------------------------------------------------
// gqls_ram
// Generic simple dual-port RAM: one write port, one read port, registered read.
// ----------------------------------------------------------------------------
module gqls_ram #(
    parameter int WIDTH = 16,
    parameter int DEPTH = 100,
    localparam int ADDR_W = $clog2(DEPTH)
) (
    input  logic              clk,
    input  logic              we,
    input  logic [ADDR_W-1:0] waddr,
    input  logic [WIDTH-1:0]  wdata,
    input  logic [ADDR_W-1:0] raddr,
    output logic [WIDTH-1:0]  rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata <= mem[raddr];
    end

endmodule

// ===== hdl/gqls_cfg.sv =====
// ----------------------------------------------------------------------------
// gqls_cfg
// Configuration register file with write decode; flags a start-epsilon write.
// ----------------------------------------------------------------------------
module gqls_cfg (
    input  logic                              clk,
    input  logic                              rst_n,
    input  logic                              write,
    input  logic [gqls_pkg::CFG_IDX_W-1:0]    index,
    input  logic [gqls_pkg::CFG_DATA_W-1:0]   data,
    output gqls_pkg::cfg_t                    cfg,
    output logic                              eps_load
);

    gqls_pkg::cfg_t cfg_reg;
    logic           eps_load_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.learn_rate    <= gqls_pkg::LEARN_RATE_RST;
            cfg_reg.discount      <= gqls_pkg::DISCOUNT_RST;
            cfg_reg.start_epsilon <= gqls_pkg::START_EPS_RST;
            cfg_reg.decay_factor  <= gqls_pkg::DECAY_RST;
            cfg_reg.floor_epsilon <= gqls_pkg::FLOOR_EPS_RST;
            cfg_reg.episode_limit <= gqls_pkg::EP_LIMIT_RST;
            eps_load_reg          <= 1'b0;
        end
        else
        begin
            eps_load_reg <= write &&
                            (gqls_pkg::cfg_index_t'(index) == gqls_pkg::CFG_START_EPSILON);
            if (write)
            begin
                unique case (gqls_pkg::cfg_index_t'(index))
                    gqls_pkg::CFG_LEARN_RATE:
                        cfg_reg.learn_rate <= data[gqls_pkg::RATE_W-1:0];
                    gqls_pkg::CFG_DISCOUNT:
                        cfg_reg.discount <= data[gqls_pkg::RATE_W-1:0];
                    gqls_pkg::CFG_START_EPSILON:
                        cfg_reg.start_epsilon <= data[gqls_pkg::EPS_W-1:0];
                    gqls_pkg::CFG_DECAY_FACTOR:
                        cfg_reg.decay_factor <= data[gqls_pkg::RATE_W-1:0];
                    gqls_pkg::CFG_FLOOR_EPSILON:
                        cfg_reg.floor_epsilon <= data[gqls_pkg::EPS_W-1:0];
                    gqls_pkg::CFG_EPISODE_LIMIT:
                        cfg_reg.episode_limit <= data[gqls_pkg::LIMIT_W-1:0];
                    default:
                    begin
                        // unknown index: ignored
                    end
                endcase
            end
        end
    end

    assign cfg      = cfg_reg;
    assign eps_load = eps_load_reg;

endmodule

// ===== hdl/gqls_mac.sv =====
// ----------------------------------------------------------------------------
// gqls_mac
// Shared scale unit: unsigned Q0.16 factor times signed operand, then >> 16
// with optional round-half-up. Three-stage pipeline, done pulses with result.
// ----------------------------------------------------------------------------
module gqls_mac #(
    parameter int OPND_W = 18
) (
    input  logic                           clk,
    input  logic                           rst_n,
    input  logic                           start,
    input  logic                           round_half,
    input  logic [gqls_pkg::RATE_W-1:0]    factor,
    input  logic signed [OPND_W-1:0]       operand,
    output logic                           done,
    output logic signed [OPND_W:0]         result
);

    localparam int PW = gqls_pkg::RATE_W + 1 + OPND_W;

    logic                          v0_reg, v1_reg, v2_reg;
    logic [gqls_pkg::RATE_W-1:0]   fac_reg;
    logic signed [OPND_W-1:0]      opnd_reg;
    logic                          rnd0_reg, rnd1_reg;
    logic signed [PW-1:0]          prod_reg;
    logic signed [OPND_W:0]        res_reg;
    logic signed [gqls_pkg::RATE_W:0] fac_s;
    logic signed [PW-1:0]          bias_s;
    logic signed [PW-1:0]          sum_s;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            v0_reg <= 1'b0;
            v1_reg <= 1'b0;
            v2_reg <= 1'b0;
        end
        else
        begin
            v0_reg <= start;
            v1_reg <= v0_reg;
            v2_reg <= v1_reg;
        end
    end

    assign fac_s = {1'b0, fac_reg};

    always_comb
    begin
        bias_s = '0;
        bias_s[gqls_pkg::MUL_SHIFT-1] = rnd1_reg;
        sum_s = prod_reg + bias_s;
    end

    always_ff @(posedge clk)
    begin
        if (start)
        begin
            fac_reg  <= factor;
            opnd_reg <= operand;
            rnd0_reg <= round_half;
        end
        if (v0_reg)
        begin
            prod_reg <= fac_s * opnd_reg;
            rnd1_reg <= rnd0_reg;
        end
        if (v1_reg)
        begin
            // arithmetic shift: floor of the scaled value
            res_reg <= sum_s[PW-1:gqls_pkg::MUL_SHIFT];
        end
    end

    assign done   = v2_reg;
    assign result = res_reg;

endmodule

// ===== hdl/grid_q_learning_step.sv =====
// Sequence: a training step passes SCAN_CUR, MOVE, SCAN_NXT, PICK_NXT, GAMMA,
// DELTA, ALPHA and WRITE, then DECAY when the episode ends (exploration decay
// pass), before DONE; a read passes READ then DONE. Throughput: one item at a
// time; two 4-entry scans of the single-read-port Q RAM and passes through the
// shared multiplier set how long a step takes. Reset clears control state at once,
// then zeroes the Q RAM one entry a cycle, GRID_DIM*GRID_DIM*4 entries (100 default).
// ----------------------------------------------------------------------------
// grid_q_learning_step
// Tabular epsilon-greedy Q-learning on a square grid, one step per command;
// sequencer around a Q RAM, a shared argmax compare and a shared multiplier.
// ----------------------------------------------------------------------------
`include "grid_q_learning_step_defines.svh"

module grid_q_learning_step #(
    parameter int GRID_DIM    = gqls_pkg::GRID_DIM_DEF,
    parameter int VALUE_WIDTH = gqls_pkg::VALUE_WIDTH_DEF
) (
    input  logic                            clk,
    input  logic                            rst_n,
    gqls_cmd_if.sink                        cmd,
    gqls_res_if.source                      res,
    input  logic                            cfg_write,
    input  logic [gqls_pkg::CFG_IDX_W-1:0]  cfg_index,
    input  logic [gqls_pkg::CFG_DATA_W-1:0] cfg_data
);

    localparam int COORD_W = $clog2(GRID_DIM + 1);
    localparam int CELL_W  = $clog2(GRID_DIM * GRID_DIM);
    localparam int ADDR_W  = CELL_W + gqls_pkg::ACT_W;
    localparam int DEPTH   = GRID_DIM * GRID_DIM * gqls_pkg::NUM_ACT;
    localparam int VW      = VALUE_WIDTH;
    localparam int DW      = VALUE_WIDTH + 2;
    localparam int SW      = DW + 1;
    localparam int OPND_W  = (DW > gqls_pkg::EPS_W + 1) ? DW : gqls_pkg::EPS_W + 1;
    localparam int FRAC    = VALUE_WIDTH - 2;
    localparam int ACT_W   = gqls_pkg::ACT_W;
    localparam int EPS_W   = gqls_pkg::EPS_W;

    localparam longint GOAL_L    = longint'(1) << FRAC;
    localparam longint PENALTY_L = (GOAL_L + gqls_pkg::PENALTY_BIAS) / gqls_pkg::PENALTY_DIV;
    localparam logic signed [DW-1:0] REWARD_GOAL = DW'(GOAL_L);
    localparam logic signed [DW-1:0] REWARD_STEP = DW'(-PENALTY_L);
    localparam logic signed [SW-1:0] Q_MAX = SW'((longint'(1) << (VW - 1)) - 1);
    localparam logic signed [SW-1:0] Q_MIN = SW'(-(longint'(1) << (VW - 1)));

    localparam logic [COORD_W-1:0] LAST     = COORD_W'(GRID_DIM - 1);
    localparam logic [COORD_W-1:0] DIM_C    = COORD_W'(GRID_DIM);
    localparam logic [ADDR_W-1:0]  CLR_LAST = ADDR_W'(DEPTH - 1);
    localparam logic [gqls_pkg::SCAN_W-1:0] SCAN_END = gqls_pkg::SCAN_W'(gqls_pkg::NUM_ACT);

    function automatic logic [CELL_W-1:0] cell_of(input logic [COORD_W-1:0] x,
                                                  input logic [COORD_W-1:0] y);
        cell_of = CELL_W'(CELL_W'(x) * CELL_W'(GRID_DIM) + CELL_W'(y));
    endfunction

    // ------------------------------------------------------------------------
    // configuration
    // ------------------------------------------------------------------------
    gqls_pkg::cfg_t cfg;
    logic           eps_load;

    gqls_cfg u_cfg (
        .clk      (clk),
        .rst_n    (rst_n),
        .write    (cfg_write),
        .index    (cfg_index),
        .data     (cfg_data),
        .cfg      (cfg),
        .eps_load (eps_load)
    );

    // ------------------------------------------------------------------------
    // state and datapath registers
    // ------------------------------------------------------------------------
    gqls_pkg::state_t state_reg, state_next;

    logic [ADDR_W-1:0]              clr_reg, clr_next;
    logic [gqls_pkg::SCAN_W-1:0]    scan_reg, scan_next;
    logic                           res_valid_reg, res_valid_next;

    logic [COORD_W-1:0]             cur_x_reg, cur_y_reg;
    logic [gqls_pkg::LIMIT_W-1:0]   ep_reg;
    logic [EPS_W-1:0]               eps_reg;
    logic [gqls_pkg::STEPS_W-1:0]   total_reg;

    logic [gqls_pkg::DRAW_W-1:0]    draw_reg, ndraw_reg;
    logic [ACT_W-1:0]               rnd_reg, nrnd_reg;
    logic                           inside_reg;

    logic signed [VW-1:0]           best_val_reg, pick_val_reg;
    logic [ACT_W-1:0]               best_idx_reg;

    logic [ACT_W-1:0]               act_reg;
    logic signed [VW-1:0]           qcur_reg;
    logic [COORD_W-1:0]             nx_reg, ny_reg;
    logic                           goal_reg, over_reg;
    logic signed [VW-1:0]           qv_reg;

    logic [ACT_W-1:0]               out_act_reg;
    logic [COORD_W-1:0]             out_x_reg, out_y_reg;
    logic                           out_goal_reg, out_over_reg;
    logic [gqls_pkg::STEPS_W-1:0]   out_total_reg;
    logic signed [VW-1:0]           out_q_reg;

    // ------------------------------------------------------------------------
    // combinational signals
    // ------------------------------------------------------------------------
    logic                           accept;
    logic                           load_out;
    logic                           scanning;
    logic [ACT_W-1:0]               scan_idx;
    logic [ACT_W-1:0]               rnd_sel;
    logic                           take_best;
    logic                           explore_cur, explore_nxt;
    logic [ACT_W-1:0]               act_c;
    logic signed [VW-1:0]           qc_c, qn_c;
    logic [COORD_W-1:0]             mx_c, my_c;
    logic                           goal_c;
    logic signed [DW-1:0]           reward_c, delta_c;
    logic signed [SW-1:0]           sum_c;
    logic signed [VW-1:0]           qv_c;
    logic [gqls_pkg::LIMIT_W-1:0]   ep_inc;
    logic                           over_c;
    logic [EPS_W-1:0]               decayed_c;

    logic                           ram_we;
    logic [ADDR_W-1:0]              ram_waddr, ram_raddr;
    logic [VW-1:0]                  ram_wdata, ram_rdata;
    logic signed [VW-1:0]           rd_q;

    logic                           mac_start, mac_round, mac_done;
    logic [gqls_pkg::RATE_W-1:0]    mac_factor;
    logic signed [OPND_W-1:0]       mac_opnd;
    logic signed [OPND_W:0]         mac_res;

    gqls_ram #(
        .WIDTH (VW),
        .DEPTH (DEPTH)
    ) u_qram (
        .clk   (clk),
        .we    (ram_we),
        .waddr (ram_waddr),
        .wdata (ram_wdata),
        .raddr (ram_raddr),
        .rdata (ram_rdata)
    );

    gqls_mac #(
        .OPND_W (OPND_W)
    ) u_mac (
        .clk        (clk),
        .rst_n      (rst_n),
        .start      (mac_start),
        .round_half (mac_round),
        .factor     (mac_factor),
        .operand    (mac_opnd),
        .done       (mac_done),
        .result     (mac_res)
    );

    assign rd_q     = ram_rdata;
    assign accept   = cmd.valid && cmd.ready;
    assign load_out = (state_reg == gqls_pkg::ST_DONE) && (!res_valid_reg || res.ready);
    assign scanning = (state_reg == gqls_pkg::ST_SCAN_CUR) ||
                      (state_reg == gqls_pkg::ST_SCAN_NXT);

    // ------------------------------------------------------------------------
    // action choice, move and update arithmetic
    // ------------------------------------------------------------------------
    always_comb
    begin
        // data returned this cycle belongs to the previous scan address
        scan_idx  = ACT_W'(scan_reg[ACT_W-1:0] - 1'b1);
        rnd_sel   = (state_reg == gqls_pkg::ST_SCAN_CUR) ? rnd_reg : nrnd_reg;
        // first entry seeds the max; later ones replace only when strictly larger
        take_best = (scan_idx == '0) || (rd_q > best_val_reg);

        explore_cur = EPS_W'(draw_reg) < eps_reg;
        explore_nxt = EPS_W'(ndraw_reg) < eps_reg;
        act_c = explore_cur ? rnd_reg : best_idx_reg;
        qc_c  = explore_cur ? pick_val_reg : best_val_reg;
        qn_c  = explore_nxt ? pick_val_reg : best_val_reg;

        mx_c = cur_x_reg;
        my_c = cur_y_reg;
        unique case (gqls_pkg::action_t'(act_c))
            gqls_pkg::ACT_X_DOWN: if (cur_x_reg != '0)  mx_c = cur_x_reg - 1'b1;
            gqls_pkg::ACT_X_UP:   if (cur_x_reg != LAST) mx_c = cur_x_reg + 1'b1;
            gqls_pkg::ACT_Y_DOWN: if (cur_y_reg != '0)  my_c = cur_y_reg - 1'b1;
            gqls_pkg::ACT_Y_UP:   if (cur_y_reg != LAST) my_c = cur_y_reg + 1'b1;
            default:
            begin
                mx_c = cur_x_reg;
                my_c = cur_y_reg;
            end
        endcase
        goal_c = (mx_c == LAST) && (my_c == LAST);

        reward_c = goal_reg ? REWARD_GOAL : REWARD_STEP;
        delta_c  = reward_c + DW'(mac_res) - DW'(qcur_reg);

        sum_c = SW'(qcur_reg) + SW'(mac_res);
        if (sum_c > Q_MAX)
        begin
            qv_c = VW'(Q_MAX);
        end
        else if (sum_c < Q_MIN)
        begin
            qv_c = VW'(Q_MIN);
        end
        else
        begin
            qv_c = VW'(sum_c);
        end

        ep_inc    = ep_reg + 1'b1;
        over_c    = goal_reg || (ep_inc >= cfg.episode_limit);
        decayed_c = mac_res[EPS_W-1:0];
    end

    // ------------------------------------------------------------------------
    // sequencer: next state
    // ------------------------------------------------------------------------
    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            gqls_pkg::ST_CLEAR:
                if (clr_reg == CLR_LAST) state_next = gqls_pkg::ST_IDLE;
            gqls_pkg::ST_IDLE:
                if (accept)
                begin
                    state_next = (cmd.operation == gqls_pkg::OP_READ) ?
                                 gqls_pkg::ST_READ : gqls_pkg::ST_SCAN_CUR;
                end
            gqls_pkg::ST_READ:
                state_next = gqls_pkg::ST_DONE;
            gqls_pkg::ST_SCAN_CUR:
                if (scan_reg == SCAN_END) state_next = gqls_pkg::ST_MOVE;
            gqls_pkg::ST_MOVE:
                state_next = gqls_pkg::ST_SCAN_NXT;
            gqls_pkg::ST_SCAN_NXT:
                if (scan_reg == SCAN_END) state_next = gqls_pkg::ST_PICK_NXT;
            gqls_pkg::ST_PICK_NXT:
                state_next = gqls_pkg::ST_GAMMA;
            gqls_pkg::ST_GAMMA:
                if (mac_done) state_next = gqls_pkg::ST_DELTA;
            gqls_pkg::ST_DELTA:
                state_next = gqls_pkg::ST_ALPHA;
            gqls_pkg::ST_ALPHA:
                if (mac_done) state_next = gqls_pkg::ST_WRITE;
            gqls_pkg::ST_WRITE:
                state_next = over_c ? gqls_pkg::ST_DECAY : gqls_pkg::ST_DONE;
            gqls_pkg::ST_DECAY:
                if (mac_done) state_next = gqls_pkg::ST_DONE;
            gqls_pkg::ST_DONE:
                if (load_out) state_next = gqls_pkg::ST_IDLE;
            default:
                state_next = gqls_pkg::ST_CLEAR;
        endcase
    end

    // ------------------------------------------------------------------------
    // sequencer: outputs
    // ------------------------------------------------------------------------
    always_comb
    begin
        clr_next       = clr_reg;
        scan_next      = '0;
        ram_we         = 1'b0;
        ram_waddr      = {cell_of(cur_x_reg, cur_y_reg), act_reg};
        ram_wdata      = qv_c;
        ram_raddr      = '0;
        mac_start      = 1'b0;
        mac_round      = 1'b1;
        mac_factor     = cfg.discount;
        mac_opnd       = OPND_W'(qn_c);
        res_valid_next = res.ready ? 1'b0 : res_valid_reg;
        if (load_out)
        begin
            res_valid_next = 1'b1;
        end

        unique case (state_reg)
            gqls_pkg::ST_CLEAR:
            begin
                ram_we    = 1'b1;
                ram_waddr = clr_reg;
                ram_wdata = '0;
                clr_next  = clr_reg + 1'b1;
            end
            gqls_pkg::ST_IDLE:
                ram_raddr = {cell_of(cmd.read_x, cmd.read_y), cmd.read_action};
            gqls_pkg::ST_SCAN_CUR:
            begin
                ram_raddr = {cell_of(cur_x_reg, cur_y_reg), scan_reg[ACT_W-1:0]};
                scan_next = (scan_reg == SCAN_END) ? '0 : scan_reg + 1'b1;
            end
            gqls_pkg::ST_SCAN_NXT:
            begin
                ram_raddr = {cell_of(nx_reg, ny_reg), scan_reg[ACT_W-1:0]};
                scan_next = (scan_reg == SCAN_END) ? '0 : scan_reg + 1'b1;
            end
            gqls_pkg::ST_PICK_NXT:
            begin
                mac_start  = 1'b1;
                mac_factor = cfg.discount;
                mac_opnd   = OPND_W'(qn_c);
            end
            gqls_pkg::ST_DELTA:
            begin
                mac_start  = 1'b1;
                mac_factor = cfg.learn_rate;
                mac_opnd   = OPND_W'(delta_c);
            end
            gqls_pkg::ST_WRITE:
            begin
                ram_we     = 1'b1;
                mac_start  = over_c;
                mac_round  = 1'b0;
                mac_factor = cfg.decay_factor;
                mac_opnd   = OPND_W'(eps_reg);
            end
            default:
            begin
                ram_raddr = '0;
            end
        endcase
    end

    // ------------------------------------------------------------------------
    // control registers
    // ------------------------------------------------------------------------
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= gqls_pkg::ST_CLEAR;
            clr_reg       <= '0;
            scan_reg      <= '0;
            res_valid_reg <= 1'b0;
            cur_x_reg     <= '0;
            cur_y_reg     <= '0;
            ep_reg        <= '0;
            eps_reg       <= gqls_pkg::START_EPS_RST;
            total_reg     <= '0;
        end
        else
        begin
            state_reg     <= state_next;
            clr_reg       <= clr_next;
            scan_reg      <= scan_next;
            res_valid_reg <= res_valid_next;

            if (state_reg == gqls_pkg::ST_WRITE)
            begin
                total_reg <= total_reg + 1'b1;
                ep_reg    <= over_c ? '0 : ep_inc;
                cur_x_reg <= over_c ? '0 : nx_reg;
                cur_y_reg <= over_c ? '0 : ny_reg;
            end

            if (eps_load)
            begin
                eps_reg <= cfg.start_epsilon;
            end
            else if ((state_reg == gqls_pkg::ST_DECAY) && mac_done)
            begin
                eps_reg <= (decayed_c < cfg.floor_epsilon) ? cfg.floor_epsilon : decayed_c;
            end
        end
    end

    // ------------------------------------------------------------------------
    // payload registers
    // ------------------------------------------------------------------------
    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            draw_reg   <= cmd.explore_draw;
            rnd_reg    <= cmd.random_action;
            ndraw_reg  <= cmd.next_explore_draw;
            nrnd_reg   <= cmd.next_random_action;
            inside_reg <= (cmd.read_x < DIM_C) && (cmd.read_y < DIM_C);
            act_reg    <= '0;
            goal_reg   <= 1'b0;
            over_reg   <= 1'b0;
        end

        if (state_reg == gqls_pkg::ST_READ)
        begin
            qv_reg <= inside_reg ? rd_q : '0;
        end

        if (scanning && (scan_reg != '0))
        begin
            if (take_best)
            begin
                best_val_reg <= rd_q;
                best_idx_reg <= scan_idx;
            end
            if (scan_idx == rnd_sel)
            begin
                pick_val_reg <= rd_q;
            end
        end

        if (state_reg == gqls_pkg::ST_MOVE)
        begin
            act_reg  <= act_c;
            qcur_reg <= qc_c;
            nx_reg   <= mx_c;
            ny_reg   <= my_c;
            goal_reg <= goal_c;
        end

        if (state_reg == gqls_pkg::ST_WRITE)
        begin
            qv_reg   <= qv_c;
            over_reg <= over_c;
        end

        if (load_out)
        begin
            out_act_reg   <= act_reg;
            out_x_reg     <= cur_x_reg;
            out_y_reg     <= cur_y_reg;
            out_goal_reg  <= goal_reg;
            out_over_reg  <= over_reg;
            out_total_reg <= total_reg;
            out_q_reg     <= qv_reg;
        end
    end

    // ------------------------------------------------------------------------
    // ports
    // ------------------------------------------------------------------------
    assign cmd.ready         = (state_reg == gqls_pkg::ST_IDLE);
    assign res.valid         = res_valid_reg;
    assign res.chosen_action = out_act_reg;
    assign res.new_x         = out_x_reg;
    assign res.new_y         = out_y_reg;
    assign res.goal_reached  = out_goal_reg;
    assign res.episode_over  = out_over_reg;
    assign res.steps_total   = out_total_reg;
    assign res.q_value       = out_q_reg;

    // ------------------------------------------------------------------------
    // assertions
    // ------------------------------------------------------------------------
    `GQLS_ASSERT_SAME(a_pos_in_grid, 1'b1, (cur_x_reg <= LAST) && (cur_y_reg <= LAST),
        "position left the grid")
    `GQLS_ASSERT_SAME(a_ram_write_state, ram_we,
        (state_reg == gqls_pkg::ST_CLEAR) || (state_reg == gqls_pkg::ST_WRITE),
        "Q RAM written outside clear or write-back")
    `GQLS_ASSERT_NEXT(a_busy_after_accept, cmd.valid && cmd.ready, !cmd.ready,
        "second beat taken while an item is in flight")
    `GQLS_ASSERT_SAME(a_result_from_done, $rose(res.valid),
        $past(state_reg == gqls_pkg::ST_DONE), "result raised outside done state")

endmodule
